FILE: hdl/srwmp_pkg.sv
// shared constants, codes and port structs for the row-wise sparse product block
// no dependencies
`default_nettype none
package srwmp_pkg;
	localparam int B_ROWS    = 256;
	localparam int B_COLS    = 64;
	localparam int B_ENTRIES = 1024;

	localparam int ROW_W   = 9;
	localparam int PTR_W   = 11;
	localparam int SLOT_W  = 10;
	localparam int COL_W   = 6;
	localparam int VAL_W   = 32;
	localparam int SUM_W   = 64;
	localparam int PTRA_W  = $clog2(B_ROWS + 1);

	localparam logic [1:0] KIND_PTR   = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_A     = 2'd2;
	localparam logic [1:0] KIND_CLOSE = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic              ptr_we;
		logic [PTRA_W-1:0] ptr_waddr;
		logic [PTR_W-1:0]  ptr_wdata;
		logic [PTRA_W-1:0] ptr_raddr;
		logic              ent_we;
		logic [SLOT_W-1:0] ent_waddr;
		logic [COL_W-1:0]  ent_wcol;
		logic [VAL_W-1:0]  ent_wval;
		logic [SLOT_W-1:0] ent_raddr;
	} bst_req_t;

	typedef struct packed {
		logic [PTR_W-1:0] ptr;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] val;
	} bst_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/srwmp_bstore.sv
// matrix b storage: row-start pointers and entry (column, value) memories
// depends on srwmp_pkg
`default_nettype none
module srwmp_bstore (
	input  wire logic                 clk,
	input  wire srwmp_pkg::bst_req_t  req,
	output      srwmp_pkg::bst_rsp_t  rsp
);
	import srwmp_pkg::*;

	logic [PTR_W-1:0]         ptr_mem [B_ROWS+1];
	logic [COL_W+VAL_W-1:0]   ent_mem [B_ENTRIES];
	logic [PTR_W-1:0]         ptr_q;
	logic [COL_W+VAL_W-1:0]   ent_q;

	always_ff @(posedge clk) begin
		if (req.ptr_we) begin
			ptr_mem[req.ptr_waddr] <= req.ptr_wdata;
		end
		ptr_q <= ptr_mem[req.ptr_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.ent_we) begin
			ent_mem[req.ent_waddr] <= {req.ent_wcol, req.ent_wval};
		end
		ent_q <= ent_mem[req.ent_raddr];
	end

	assign rsp.ptr = ptr_q;
	assign rsp.col = ent_q[COL_W+VAL_W-1:VAL_W];
	assign rsp.val = ent_q[VAL_W-1:0];
endmodule
`default_nettype wire

FILE: hdl/srwmp_mac.sv
// shared multiply-accumulate unit: registered 32x32 product, saturating 64-bit add
// depends on srwmp_pkg
`default_nettype none
module srwmp_mac (
	input  wire logic                              clk,
	input  wire logic                              mul_en,
	input  wire logic signed [srwmp_pkg::VAL_W-1:0] a,
	input  wire logic signed [srwmp_pkg::VAL_W-1:0] b,
	input  wire logic signed [srwmp_pkg::SUM_W-1:0] acc,
	output      logic signed [srwmp_pkg::SUM_W-1:0] sum
);
	import srwmp_pkg::*;

	logic signed [SUM_W-1:0] prod_q;
	logic signed [SUM_W:0]   wide;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= SUM_W'(a * b);
		end
	end

	always_comb begin
		wide = {acc[SUM_W-1], acc} + {prod_q[SUM_W-1], prod_q};
		if (wide[SUM_W] != wide[SUM_W-1]) begin
			sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum = wide[SUM_W-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: hdl/sparse_row_wise_matrix_product.sv
// row-wise sparse product top: command port, sequencer, column sums, apb register
// pointer/entry writes finish on acceptance; an a entry walks its b entries in turn
// error word shows the cycle after the a entry; close words stream out over the column sweep
// one item at a time (busy high meanwhile); the single mac unit is the limiting resource
// asynchronous active-low reset clears control, touch marks and b_rows_in_use (to 256)
// results cannot be stalled: each word is shown for exactly one cycle on result_strobe
`default_nettype none
module sparse_row_wise_matrix_product (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic [1:0]                         kind,
	input  wire logic [srwmp_pkg::ROW_W-1:0]        b_row,
	input  wire logic [srwmp_pkg::PTR_W-1:0]        entry_pointer,
	input  wire logic [srwmp_pkg::SLOT_W-1:0]       entry_slot,
	input  wire logic [srwmp_pkg::COL_W-1:0]        column,
	input  wire logic signed [srwmp_pkg::VAL_W-1:0] value,
	output      logic                               result_strobe,
	output      logic [srwmp_pkg::COL_W-1:0]        result_column,
	output      logic signed [srwmp_pkg::SUM_W-1:0] result_value,
	output      logic                               has_entry,
	output      logic                               last_of_row,
	output      logic                               status,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output      logic [31:0]                        prdata,
	output      logic                               pready
);
	import srwmp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PTR0 = 4'd1;
	localparam logic [3:0] S_PTR1 = 4'd2;
	localparam logic [3:0] S_WRD  = 4'd3;
	localparam logic [3:0] S_WMUL = 4'd4;
	localparam logic [3:0] S_WACC = 4'd5;
	localparam logic [3:0] S_CRD  = 4'd6;
	localparam logic [3:0] S_CCHK = 4'd7;
	localparam logic [3:0] S_CFIN = 4'd8;

	logic [3:0]              state_q;
	logic [ROW_W-1:0]        rows_q;
	logic [ROW_W-1:0]        row_q;
	logic [VAL_W-1:0]        aval_q;
	logic [PTR_W-1:0]        e_q;
	logic [PTR_W-1:0]        end_q;
	logic [COL_W-1:0]        col_q;
	logic [COL_W:0]          cnt_q;
	logic [B_COLS-1:0]       touched_q;
	logic                    pend_q;
	logic [COL_W-1:0]        pcol_q;
	logic [SUM_W-1:0]        pval_q;

	logic                    accept;
	logic                    row_bad;
	bst_req_t                breq;
	bst_rsp_t                brsp;
	logic [SUM_W-1:0]        sums_mem [B_COLS];
	logic [SUM_W-1:0]        sums_rd_q;
	logic [COL_W-1:0]        sums_raddr;
	logic [SUM_W-1:0]        acc_in;
	logic signed [SUM_W-1:0] mac_sum;
	logic [PTR_W-1:0]        end_clamped;
	logic                    col_hit;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign pready = 1'b1;
	assign prdata = {{(32-ROW_W){1'b0}}, rows_q};

	// an a entry is out of range against both the register and the store depth
	assign row_bad = (b_row >= rows_q) || ({1'b0, b_row} >= (ROW_W+1)'(B_ROWS));

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROW_W'(B_ROWS);
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			rows_q <= pwdata[ROW_W-1:0];
		end
	end

	// b store requests
	always_comb begin
		breq           = '0;
		breq.ptr_we    = accept && kind == KIND_PTR && ({1'b0, b_row} <= (ROW_W+1)'(B_ROWS));
		breq.ptr_waddr = PTRA_W'(b_row);
		breq.ptr_wdata = entry_pointer;
		breq.ptr_raddr = (state_q == S_PTR0) ? PTRA_W'(row_q + ROW_W'(1)) : PTRA_W'(b_row);
		breq.ent_we    = accept && kind == KIND_ENTRY &&
		                 ({1'b0, entry_slot} < (SLOT_W+1)'(B_ENTRIES));
		breq.ent_waddr = entry_slot;
		breq.ent_wcol  = column;
		breq.ent_wval  = value;
		breq.ent_raddr = e_q[SLOT_W-1:0];
	end

	srwmp_bstore u_bstore (
		.clk (clk),
		.req (breq),
		.rsp (brsp)
	);

	// row end clamped to the entry store depth
	assign end_clamped = (brsp.ptr > PTR_W'(B_ENTRIES)) ? PTR_W'(B_ENTRIES) : brsp.ptr;

	// column sums: untouched columns read as zero through the touch marks
	assign sums_raddr = (state_q == S_WMUL) ? brsp.col : cnt_q[COL_W-1:0];
	assign acc_in     = touched_q[col_q] ? sums_rd_q : '0;
	assign col_hit    = ({1'b0, col_q} < (COL_W+1)'(B_COLS));

	always_ff @(posedge clk) begin
		if (state_q == S_WACC && col_hit) begin
			sums_mem[col_q] <= mac_sum;
		end
		sums_rd_q <= sums_mem[sums_raddr];
	end

	srwmp_mac u_mac (
		.clk    (clk),
		.mul_en (state_q == S_WMUL),
		.a      (aval_q),
		.b      (brsp.val),
		.acc    (acc_in),
		.sum    (mac_sum)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= b_row;
			aval_q <= value;
		end
		if (state_q == S_PTR0) begin
			e_q <= brsp.ptr;
		end else if (state_q == S_WACC) begin
			e_q <= e_q + PTR_W'(1);
		end
		if (state_q == S_PTR1) begin
			end_q <= end_clamped;
		end
		if (state_q == S_WMUL) begin
			col_q <= brsp.col;
		end
		if (state_q == S_CCHK && touched_q[cnt_q[COL_W-1:0]] && sums_rd_q != '0) begin
			pcol_q <= cnt_q[COL_W-1:0];
			pval_q <= sums_rd_q;
		end
	end

	// sequencer and result words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			touched_q     <= '0;
			cnt_q         <= '0;
			pend_q        <= 1'b0;
			result_strobe <= 1'b0;
			result_column <= '0;
			result_value  <= '0;
			has_entry     <= 1'b0;
			last_of_row   <= 1'b0;
			status        <= STATUS_OK;
		end else begin
			result_strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_A: begin
								if (row_bad) begin
									result_strobe <= 1'b1;
									result_column <= '0;
									result_value  <= '0;
									has_entry     <= 1'b0;
									last_of_row   <= 1'b0;
									status        <= STATUS_ERR;
								end else begin
									state_q <= S_PTR0;
								end
							end
							KIND_CLOSE: begin
								cnt_q   <= '0;
								pend_q  <= 1'b0;
								state_q <= S_CRD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_PTR0: state_q <= S_PTR1;
				S_PTR1: state_q <= S_WRD;
				S_WRD: begin
					state_q <= (e_q < end_q) ? S_WMUL : S_IDLE;
				end
				S_WMUL: state_q <= S_WACC;
				S_WACC: begin
					if (col_hit) begin
						touched_q[col_q] <= 1'b1;
					end
					state_q <= S_WRD;
				end
				S_CRD: state_q <= S_CCHK;
				S_CCHK: begin
					// one word is held back so the final one can carry last_of_row
					if (touched_q[cnt_q[COL_W-1:0]] && sums_rd_q != '0) begin
						if (pend_q) begin
							result_strobe <= 1'b1;
							result_column <= pcol_q;
							result_value  <= pval_q;
							has_entry     <= 1'b1;
							last_of_row   <= 1'b0;
							status        <= STATUS_OK;
						end
						pend_q <= 1'b1;
					end
					cnt_q   <= cnt_q + (COL_W+1)'(1);
					state_q <= (cnt_q == (COL_W+1)'(B_COLS - 1)) ? S_CFIN : S_CRD;
				end
				S_CFIN: begin
					result_strobe <= 1'b1;
					result_column <= pend_q ? pcol_q : '0;
					result_value  <= pend_q ? pval_q : '0;
					has_entry     <= pend_q;
					last_of_row   <= 1'b1;
					status        <= STATUS_OK;
					touched_q     <= '0;
					state_q       <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// error words never carry an entry or close a row
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && status |-> !has_entry && !last_of_row)
		else $error("error word carries entry or last flag");

	// emitted entries never hold an exact zero sum
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && has_entry |-> result_value != '0)
		else $error("zero sum emitted");

	// an ok word without an entry is the empty-row marker
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !has_entry && !status |-> last_of_row)
		else $error("empty marker without last flag");

	// the close sweep leaves the touch marks cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CFIN |=> touched_q == '0)
		else $error("touch marks not cleared after close");
endmodule
`default_nettype wire
